FILE: rtl/core/button_gesture_classifier_macros.svh
// ----------------------------------------------------------------------------
// Button gesture classifier: assertion macros
// Clocked, reset-gated property checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_MACROS_SVH

// property holds at every edge outside reset
`define BGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define BGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types, register map and event codes of the gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

	localparam int KEY_COUNT        = 2;
	localparam int EDGES_FOR_DOUBLE = 4;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
	localparam logic [2:0] REG_SHORT_WINDOW = 3'd1;
	localparam logic [2:0] REG_MEDIUM_WIN   = 3'd2;
	localparam logic [2:0] REG_REPEAT_PER   = 3'd3;
	localparam logic [2:0] REG_VLONG_REPS   = 3'd4;
	localparam logic [2:0] REG_SHORT_MIN    = 3'd5;
	localparam logic [2:0] REG_MULTI_PRESS  = 3'd6;

	localparam logic [15:0] RST_DEBOUNCE     = 16'd20;
	localparam logic [15:0] RST_SHORT_WINDOW = 16'd500;
	localparam logic [15:0] RST_MEDIUM_WIN   = 16'd1000;
	localparam logic [15:0] RST_REPEAT_PER   = 16'd200;
	localparam logic [7:0]  RST_VLONG_REPS   = 8'd10;
	localparam logic [15:0] RST_SHORT_MIN    = 16'd60;
	localparam logic [15:0] RST_MULTI_PRESS  = 16'd400;

	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_SHORT  = 3'd1;
	localparam logic [2:0] EV_MEDIUM = 3'd2;
	localparam logic [2:0] EV_DOUBLE = 3'd3;
	localparam logic [2:0] EV_VLONG  = 3'd4;
	localparam logic [2:0] EV_REPEAT = 3'd5;

	typedef struct packed {
		logic [15:0] debounce_ticks;
		logic [15:0] short_window_ticks;
		logic [15:0] medium_window_ticks;
		logic [15:0] repeat_period_ticks;
		logic [7:0]  very_long_repeats;
		logic [15:0] short_min_ticks;
		logic [15:0] multi_press_ticks;
	} cfg_t;

endpackage

FILE: rtl/core/bgc_if.sv
// ----------------------------------------------------------------------------
// bgc_key_if / bgc_event_if
// Valid/ready channels for key samples in and gesture events out.
// ----------------------------------------------------------------------------
interface bgc_key_if;
	logic       valid;
	logic       ready;
	logic [1:0] key_sample;

	modport source (output valid, output key_sample, input ready);
	modport sink (input valid, input key_sample, output ready);
endinterface

interface bgc_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] press_event;
	logic [1:0] event_key;

	modport source (output valid, output press_event, output event_key, input ready);
	modport sink (input valid, input press_event, input event_key, output ready);
endinterface

FILE: rtl/core/bgc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgc_cfg_regs
// APB register file holding the timing thresholds.
// ----------------------------------------------------------------------------
module bgc_cfg_regs
	import bgc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks      <= RST_DEBOUNCE;
			cfg_q.short_window_ticks  <= RST_SHORT_WINDOW;
			cfg_q.medium_window_ticks <= RST_MEDIUM_WIN;
			cfg_q.repeat_period_ticks <= RST_REPEAT_PER;
			cfg_q.very_long_repeats   <= RST_VLONG_REPS;
			cfg_q.short_min_ticks     <= RST_SHORT_MIN;
			cfg_q.multi_press_ticks   <= RST_MULTI_PRESS;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DEBOUNCE:     cfg_q.debounce_ticks      <= pwdata[15:0];
				REG_SHORT_WINDOW: cfg_q.short_window_ticks  <= pwdata[15:0];
				REG_MEDIUM_WIN:   cfg_q.medium_window_ticks <= pwdata[15:0];
				REG_REPEAT_PER:   cfg_q.repeat_period_ticks <= pwdata[15:0];
				REG_VLONG_REPS:   cfg_q.very_long_repeats   <= pwdata[7:0];
				REG_SHORT_MIN:    cfg_q.short_min_ticks     <= pwdata[15:0];
				REG_MULTI_PRESS:  cfg_q.multi_press_ticks   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DEBOUNCE:     prdata = {16'd0, cfg_q.debounce_ticks};
			REG_SHORT_WINDOW: prdata = {16'd0, cfg_q.short_window_ticks};
			REG_MEDIUM_WIN:   prdata = {16'd0, cfg_q.medium_window_ticks};
			REG_REPEAT_PER:   prdata = {16'd0, cfg_q.repeat_period_ticks};
			REG_VLONG_REPS:   prdata = {24'd0, cfg_q.very_long_repeats};
			REG_SHORT_MIN:    prdata = {16'd0, cfg_q.short_min_ticks};
			REG_MULTI_PRESS:  prdata = {16'd0, cfg_q.multi_press_ticks};
			default:          prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/bgc_fsm.sv
// ----------------------------------------------------------------------------
// bgc_fsm
// Gesture state: countdown, tick counter, edge detect and mode machine.
// Event for the current item is combinational; state updates on step.
// ----------------------------------------------------------------------------
module bgc_fsm
	import bgc_pkg::*;
#(
	parameter int NUM_KEYS     = KEY_COUNT,
	parameter int DOUBLE_EDGES = EDGES_FOR_DOUBLE
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [1:0] key_sample,
	input  cfg_t       cfg,
	output logic [2:0] press_event,
	output logic [1:0] event_key
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_DEBOUNCE,
		MODE_CHECK,
		MODE_REPEAT
	} mode_t;

	localparam logic [1:0] KEY_MAX  = 2'(NUM_KEYS);
	localparam logic [7:0] EDGE_DBL = 8'(DOUBLE_EDGES);
	localparam logic [7:0] EDGE_M1  = 8'(DOUBLE_EDGES - 1);

	logic        was_pressed_q;
	mode_t       mode_q;
	logic [15:0] countdown_q;
	logic [7:0]  repeat_count_q;
	logic [7:0]  edge_count_q;
	logic [15:0] tick_now_q;
	logic [15:0] press_length_q;
	logic [15:0] two_press_span_q;
	logic [1:0]  held_key_q;

	mode_t       mode_n;
	logic [15:0] countdown_n;
	logic [7:0]  repeat_count_n;
	logic [7:0]  repeat_inc;
	logic [7:0]  edge_count_n;
	logic [15:0] tick_n;
	logic [15:0] press_length_n;
	logic [15:0] two_press_span_n;
	logic [1:0]  held_upd;
	logic [1:0]  held_key_n;
	logic        pressed;
	logic [2:0]  ev_raw;
	logic [2:0]  ev;

	assign pressed    = (key_sample != 2'd0) && (key_sample <= KEY_MAX);
	assign tick_n     = tick_now_q + 16'd1;
	assign repeat_inc = repeat_count_q + 8'd1;

	always_comb begin
		mode_n           = mode_q;
		countdown_n      = (countdown_q != 16'd0) ? countdown_q - 16'd1 : countdown_q;
		repeat_count_n   = repeat_count_q;
		edge_count_n     = edge_count_q;
		press_length_n   = press_length_q;
		two_press_span_n = two_press_span_q;
		held_upd         = pressed ? key_sample : held_key_q;
		ev_raw           = EV_NONE;

		if (pressed && !was_pressed_q) begin
			press_length_n = tick_n;
			if (edge_count_q == 8'd0) begin
				two_press_span_n = tick_n;
			end
			edge_count_n = edge_count_q + 8'd1;
			if (mode_q == MODE_IDLE) begin
				mode_n      = MODE_DEBOUNCE;
				countdown_n = cfg.debounce_ticks;
			end
		end else if (pressed) begin
			if (countdown_n == 16'd0) begin
				case (mode_q)
					MODE_DEBOUNCE: begin
						mode_n      = MODE_CHECK;
						countdown_n = cfg.short_window_ticks;
					end
					MODE_CHECK: begin
						mode_n         = MODE_REPEAT;
						countdown_n    = cfg.medium_window_ticks;
						repeat_count_n = 8'd0;
					end
					MODE_REPEAT: begin
						countdown_n    = cfg.repeat_period_ticks;
						repeat_count_n = repeat_inc;
						ev_raw = (repeat_inc == cfg.very_long_repeats) ? EV_VLONG : EV_REPEAT;
					end
					default: ;
				endcase
			end
		end else if (was_pressed_q) begin
			press_length_n = tick_n - press_length_q;
			if (edge_count_q == EDGE_M1) begin
				two_press_span_n = tick_n - two_press_span_q;
			end
			edge_count_n = edge_count_q + 8'd1;
			if (mode_q == MODE_CHECK || mode_q == MODE_REPEAT) begin
				countdown_n = cfg.debounce_ticks;
			end
		end else begin
			if (countdown_n == 16'd0) begin
				case (mode_q)
					MODE_CHECK: begin
						if (press_length_q > cfg.short_min_ticks) begin
							edge_count_n = 8'd0;
							ev_raw       = EV_SHORT;
						end else if (edge_count_q == EDGE_DBL) begin
							if (two_press_span_q < cfg.multi_press_ticks) begin
								ev_raw = EV_DOUBLE;
							end
							edge_count_n = 8'd0;
						end
						mode_n = MODE_IDLE;
					end
					MODE_REPEAT: begin
						if (repeat_count_q == 8'd0) begin
							ev_raw = EV_MEDIUM;
						end
						edge_count_n = 8'd0;
						mode_n       = MODE_IDLE;
					end
					default: ;
				endcase
			end
		end

		ev         = (held_upd == 2'd0) ? EV_NONE : ev_raw;
		held_key_n = (ev != EV_NONE) ? 2'd0 : held_upd;
	end

	assign press_event = ev;
	assign event_key   = (ev != EV_NONE) ? held_upd : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_pressed_q    <= 1'b0;
			mode_q           <= MODE_IDLE;
			countdown_q      <= '0;
			repeat_count_q   <= '0;
			edge_count_q     <= '0;
			tick_now_q       <= '0;
			press_length_q   <= '0;
			two_press_span_q <= '0;
			held_key_q       <= '0;
		end else if (step) begin
			was_pressed_q    <= pressed;
			mode_q           <= mode_n;
			countdown_q      <= countdown_n;
			repeat_count_q   <= repeat_count_n;
			edge_count_q     <= edge_count_n;
			tick_now_q       <= tick_n;
			press_length_q   <= press_length_n;
			two_press_span_q <= two_press_span_n;
			held_key_q       <= held_key_n;
		end
	end

endmodule

FILE: rtl/core/button_gesture_classifier.sv
// Path: an accepted item passes the input register, then the result register, to the output.
// Throughput: one item per cycle unless the output stalls; gesture state updates once per item.
// Input is taken while a result waits only when the input register is empty.
// Reset: arst_n clears the gesture state, pipeline valids and loads register defaults.
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Classifies short, medium, double, repeat and very long presses from
// millisecond key samples.
// ----------------------------------------------------------------------------
`include "button_gesture_classifier_macros.svh"

module button_gesture_classifier
	import bgc_pkg::*;
#(
	parameter int NUM_KEYS     = KEY_COUNT,
	parameter int DOUBLE_EDGES = EDGES_FOR_DOUBLE
)
(
	input  logic              clk,
	input  logic              arst_n,
	bgc_key_if.sink           key_in,
	bgc_event_if.source       event_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [1:0] key_s1;
	logic       out_valid_q;
	logic [2:0] press_event_q;
	logic [1:0] event_key_q;
	logic       advance;
	logic       step;
	logic [2:0] ev_comb;
	logic [1:0] key_comb;
	logic       key_agree;

	bgc_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign advance      = !out_valid_q || event_out.ready;
	assign step         = valid_s1 && advance;
	assign key_in.ready = !valid_s1 || advance;

	bgc_fsm #(
		.NUM_KEYS    (NUM_KEYS),
		.DOUBLE_EDGES(DOUBLE_EDGES)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.key_sample (key_s1),
		.cfg        (cfg),
		.press_event(ev_comb),
		.event_key  (key_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (key_in.ready) begin
				valid_s1 <= key_in.valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_in.ready && key_in.valid) begin
			key_s1 <= key_in.key_sample;
		end
		if (step) begin
			press_event_q <= ev_comb;
			event_key_q   <= key_comb;
		end
	end

	assign event_out.valid       = out_valid_q;
	assign event_out.press_event = press_event_q;
	assign event_out.event_key   = event_key_q;

	assign key_agree = (press_event_q == EV_NONE) == (event_key_q == 2'd0);

	`BGC_ASSERT(a_key_tracks_event, !out_valid_q || key_agree, "event key disagrees with event code")
	`BGC_ASSERT(a_event_in_range, !out_valid_q || (press_event_q <= EV_REPEAT), "event code out of range")
	`BGC_ASSERT_NEXT(a_stage_held, valid_s1 && !advance, valid_s1, "stalled item lost")
	`BGC_ASSERT_NEXT(a_result_follows, step, out_valid_q, "processed item produced no result")

endmodule
